// ===== rtl/rme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants for the modular exponentiation core.
// ----------------------------------------------------------------------------
package rme_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_EXP = 2'd2;

    // opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // sequencer to multiplier
    typedef struct packed {
        logic start;
    } t_mm_ctrl;

    // multiplier to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

// ===== rtl/rme_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_modmul
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle,
// MSB first, doubling and conditionally adding with reduction each step.
// Requires a < m; b may take any value.
// ----------------------------------------------------------------------------
module rme_modmul
    import rme_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mm_ctrl             i_ctrl,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output t_mm_status           o_status,
    output logic [WORD_BITS-1:0] o_product
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_r, n_r;
    logic [WORD_BITS-1:0] r_a, n_a;
    logic [WORD_BITS-1:0] r_b, n_b;
    logic [WORD_BITS-1:0] r_m, n_m;

    logic [WORD_BITS:0]   dbl_sum, add_sum;
    logic [WORD_BITS-1:0] dbl_mod, add_mod;

    // one step: r = 2r mod m, then r = r + a mod m when the bit is set
    always_comb begin
        dbl_sum = {1'b0, r_r} + {1'b0, r_r};
        if (dbl_sum >= {1'b0, r_m}) begin
            dbl_mod = WORD_BITS'(dbl_sum - {1'b0, r_m});
        end else begin
            dbl_mod = dbl_sum[WORD_BITS-1:0];
        end
        add_sum = {1'b0, dbl_mod} + {1'b0, r_a};
        if (!r_b[WORD_BITS-1]) begin
            add_mod = dbl_mod;
        end else if (add_sum >= {1'b0, r_m}) begin
            add_mod = WORD_BITS'(add_sum - {1'b0, r_m});
        end else begin
            add_mod = add_sum[WORD_BITS-1:0];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_r    = r_r;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        if (r_busy) begin
            n_r   = add_mod;
            n_b   = {r_b[WORD_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_LAST;
            n_r    = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_r <= n_r;
        r_a <= n_a;
        r_b <= n_b;
        r_m <= n_m;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = r_r;

endmodule

// ===== rtl/rsa_modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_core
// Right-to-left square-and-multiply modular exponentiation on one shared
// bit-serial modular multiplier; n, e and d are loaded by software.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_opcode, i_message
// out      output     o_out_valid / i_out_stall  o_result
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction at a time. The message is reduced mod n (one product), then
// each exponent bit takes a sequencing step in ST_STEP, a square and, when set, a
// multiply; the square after the top set bit is skipped.
// A modulus of 0 or 1 gives 0 through ST_FIN without using the multiplier.
// Reset: n = 1, e = d = 0, no result pending. Synchronous, active low.
// The next transaction is accepted while a result waits on a stalled output.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_core
    import rme_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  logic [WORD_BITS-1:0]    i_message,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [WORD_BITS-1:0]    o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]    i_cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_SQR    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [WORD_BITS-1:0] r_modulus, r_pub_exp, r_priv_exp;
    logic [2:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_ex, n_ex;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_sq, n_sq;
    logic [WORD_BITS-1:0] r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0] r_result, n_result;

    t_mm_ctrl             mm_ctrl;
    t_mm_status           mm_stat;
    logic [WORD_BITS-1:0] mm_a, mm_b, mm_prod;

    logic in_accept, out_take, cfg_write, mod_trivial;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign mod_trivial = (r_modulus[WORD_BITS-1:1] == '0);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= WORD_BITS'(1);
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_MODULUS:     r_modulus  <= i_cfg_data;
                CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rme_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mm_ctrl),
        .i_a       (mm_a),
        .i_b       (mm_b),
        .i_m       (r_modulus),
        .o_status  (mm_stat),
        .o_product (mm_prod)
    );

    always_comb begin
        n_state       = r_state;
        n_ex          = r_ex;
        n_acc         = r_acc;
        n_sq          = r_sq;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid && !out_take;
        n_result      = r_result;
        mm_ctrl.start = 1'b0;
        mm_a          = r_sq;
        mm_b          = r_sq;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_ex = (i_opcode == OP_DECRYPT) ? r_priv_exp : r_pub_exp;
                    if (mod_trivial) begin
                        n_pend  = '0;
                        n_state = ST_FIN;
                    end else begin
                        // base mod n computed as 1 * message mod n
                        mm_ctrl.start = 1'b1;
                        mm_a          = WORD_BITS'(1);
                        mm_b          = i_message;
                        n_state       = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) begin
                    n_sq    = mm_prod;
                    n_acc   = WORD_BITS'(1);
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_ex == '0) begin
                    n_pend  = r_acc;
                    n_state = ST_FIN;
                end else if (r_ex[0]) begin
                    mm_ctrl.start = 1'b1;
                    mm_a          = r_acc;
                    n_state       = ST_MUL;
                end else begin
                    mm_ctrl.start = 1'b1;
                    n_state       = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_stat.done) begin
                    n_acc = mm_prod;
                    if (r_ex[WORD_BITS-1:1] == '0) begin
                        // last set bit: the trailing square is not needed
                        n_pend  = mm_prod;
                        n_state = ST_FIN;
                    end else begin
                        mm_ctrl.start = 1'b1;
                        n_state       = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mm_stat.done) begin
                    n_sq    = mm_prod;
                    n_ex    = {1'b0, r_ex[WORD_BITS-1:1]};
                    n_state = ST_STEP;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || out_take) begin
                    n_result    = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_ex     <= n_ex;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_pend   <= n_pend;
        r_result <= n_result;
    end

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_ctrl.start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_stat.done |-> (r_state == ST_REDUCE || r_state == ST_MUL ||
                          r_state == ST_SQR))
        else $error("multiplier result with no waiting state");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after acceptance");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && i_out_stall) |=> (r_state == ST_FIN))
        else $error("pending result overwrote a stalled output");

endmodule
